@@ src/mi4_pkg.sv @@
// shared types, defaults and index helper for the 4x4 adjugate inverse core
package mi4_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM_A,
    S_TERM_B,
    S_MUL1,
    S_TERM_C,
    S_MUL2,
    S_TERM_END,
    S_DET_LOAD,
    S_DET_MUL,
    S_DET_END,
    S_DET_FIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } div_sts_t;

  // store address of factor s of product term t for cofactor k
  // terms 0..2 walk rows r+1..r+3, terms 3..5 walk them backwards
  function automatic logic [3:0] cof_elem_addr(input logic [3:0] k, input logic [2:0] t,
                                               input logic [1:0] s);
    logic [1:0] row_off;
    logic [2:0] rot;
    logic [2:0] idx;
    logic [1:0] col_off;
    row_off = (t >= 3'd3) ? (2'd3 - s) : (2'd1 + s);
    rot     = (t >= 3'd3) ? (t - 3'd3) : t;
    idx     = rot + {1'b0, s};
    if (idx >= 3'd3) begin
      idx = idx - 3'd3;
    end
    col_off = idx[1:0] + 2'd1;
    return {k[3:2] + row_off, k[1:0] + col_off};
  endfunction

endpackage

@@ src/mi4_div.sv @@
// serial restoring divider with signed saturation of the quotient
module mi4_div #(
  parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
  parameter int NUM_WIDTH  = 130,
  parameter int DEN_WIDTH  = 132
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mi4_pkg::div_ctl_t            ctl,
  input  logic [NUM_WIDTH-1:0]         num_mag,
  input  logic [DEN_WIDTH-1:0]         den,
  output mi4_pkg::div_sts_t            sts,
  output logic signed [DATA_WIDTH-1:0] quo
);
  import mi4_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NUM_WIDTH-1:0] num_r, num_nxt;
  logic [DEN_WIDTH-1:0] den_r, den_nxt;
  logic [DEN_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH:0]  q_r, q_nxt;
  logic                 over_r, over_nxt;
  logic                 neg_r, neg_nxt;

  logic [DEN_WIDTH:0]   rem_sh;
  logic [DEN_WIDTH:0]   diff;
  logic                 q_big, q_ge, q_gt, sat;

  assign rem_sh = {rem_r, num_r[NUM_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    over_nxt = over_r;
    neg_nxt  = neg_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num_mag;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = '0;
      over_nxt = 1'b0;
      neg_nxt  = ctl.neg;
    end else if (busy_r) begin
      num_nxt  = {num_r[NUM_WIDTH-2:0], 1'b0};
      rem_nxt  = diff[DEN_WIDTH] ? rem_sh[DEN_WIDTH-1:0] : diff[DEN_WIDTH-1:0];
      over_nxt = over_r | q_r[DATA_WIDTH];
      q_nxt    = {q_r[DATA_WIDTH-1:0], ~diff[DEN_WIDTH]};
      cnt_nxt  = cnt_r + CW'(1);
      if (cnt_r == CW'(NUM_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    over_r <= over_nxt;
    neg_r  <= neg_nxt;
  end

  // compare against 2^(DATA_WIDTH-1)
  assign q_big = over_r | q_r[DATA_WIDTH];
  assign q_ge  = q_big | q_r[DATA_WIDTH-1];
  assign q_gt  = q_big | (q_r[DATA_WIDTH-1] & (|q_r[DATA_WIDTH-2:0]));

  always_comb begin
    if (neg_r) begin
      sat = q_gt;
      quo = q_gt ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : -q_r[DATA_WIDTH-1:0];
    end else begin
      sat = q_ge;
      quo = q_ge ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : q_r[DATA_WIDTH-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.sat  = sat;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without a running division");
`endif

endmodule

@@ src/matrix4_inverse_adjugate_core.sv @@
// 4x4 signed fixed-point matrix inverse by adjugate, iterative shared multiplier
// usage:
//   in_ channel: one matrix element per transaction (row*4+col index, signed value,
//   compute_now). every transaction writes the element store; one with compute_now
//   set also starts the inversion on the stored matrix.
//   out_ channel: sixteen transactions per inversion, row-major, last_of_run on
//   the sixteenth. a zero determinant gives zero values with singular set.
// operation:
//   an inversion keeps in_stall high through cofactor and determinant work on
//   one serial shift-add multiplier (one multiplier bit per cycle), then through
//   restoring division, one quotient bit per cycle.
// reset:
//   synchronous active low; clears the element store to zero and idles the block.
// stall:
//   results sit in an output register; a stalled result holds and the sequencer
//   waits before loading the next one. once the last result is loaded, new load
//   transactions are taken while it still waits.
module matrix4_inverse_adjugate_core #(
  parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_element_index,
  input  logic signed [31:0] in_element_value,
  input  logic               in_compute_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               out_singular,
  output logic               out_saturated,
  output logic               out_last_of_run
);
  import mi4_pkg::*;

  // cofactor, product and numerator widths
  localparam int CW = 3 * DATA_WIDTH + 2;
  localparam int PW = 4 * DATA_WIDTH + 4;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int BW = $clog2(DATA_WIDTH);

  state_t state_r, state_nxt;

  logic signed [DATA_WIDTH-1:0] store_r [16];
  logic signed [CW-1:0]         cof_r [16];

  logic [3:0]              k_r, k_nxt;
  logic [2:0]              t_r, t_nxt;
  logic [BW-1:0]           bit_r, bit_nxt;
  logic signed [PW-1:0]    mcand_r, mcand_nxt;
  logic [DATA_WIDTH-1:0]   mplier_r, mplier_nxt;
  logic signed [PW-1:0]    acc_r, acc_nxt;
  logic signed [PW-1:0]    sum_r, sum_nxt;
  logic                    det_zero_r, det_zero_nxt;
  logic                    det_neg_r, det_neg_nxt;
  logic [PW-1:0]           dmag_r, dmag_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_row_r, out_row_nxt;
  logic [1:0]              out_col_r, out_col_nxt;
  logic signed [31:0]      out_value_r, out_value_nxt;
  logic                    out_sing_r, out_sing_nxt;
  logic                    out_sat_r, out_sat_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_take;
  logic                    out_free;
  logic                    mul_last;
  logic signed [PW-1:0]    mul_acc;
  logic                    term_neg;
  logic [3:0]              rd_addr;
  logic signed [DATA_WIDTH-1:0] rd_elem;
  logic signed [CW-1:0]    cof_div;
  logic [CW-1:0]           cof_mag;
  logic                    cof_we;

  div_ctl_t                div_ctl;
  div_sts_t                div_sts;
  logic signed [DATA_WIDTH-1:0] div_quo;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // shared multiplier: one signed multiplier bit per cycle, top bit weighs negative
  assign mul_last = (bit_r == BW'(DATA_WIDTH - 1));
  always_comb begin
    mul_acc = acc_r;
    if (mplier_r[0]) begin
      mul_acc = mul_last ? (acc_r - mcand_r) : (acc_r + mcand_r);
    end
  end

  // minus terms and odd row+col positions flip the sign of the product
  assign term_neg = (t_r >= 3'd3) ^ k_r[2] ^ k_r[0];

  always_comb begin
    unique case (state_r)
      S_TERM_A: rd_addr = cof_elem_addr(k_r, t_r, 2'd0);
      S_TERM_B: rd_addr = cof_elem_addr(k_r, t_r, 2'd1);
      S_TERM_C: rd_addr = cof_elem_addr(k_r, t_r, 2'd2);
      default:  rd_addr = k_r;
    endcase
  end
  assign rd_elem = store_r[rd_addr];

  // inverse(i,j) uses cofactor(j,i)
  assign cof_div = cof_r[{k_r[1:0], k_r[3:2]}];
  assign cof_mag = cof_div[CW-1] ? CW'(-cof_div) : CW'(cof_div);

  assign div_ctl.start = (state_r == S_DIV_GO);
  assign div_ctl.neg   = cof_div[CW-1] ^ det_neg_r;

  mi4_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .NUM_WIDTH (NW),
    .DEN_WIDTH (PW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (div_ctl),
    .num_mag({cof_mag, {(2 * FRAC_BITS){1'b0}}}),
    .den    (dmag_r),
    .sts    (div_sts),
    .quo    (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_take && in_compute_now) state_nxt = S_TERM_A;
      S_TERM_A:   state_nxt = S_TERM_B;
      S_TERM_B:   state_nxt = S_MUL1;
      S_MUL1:     if (mul_last) state_nxt = S_TERM_C;
      S_TERM_C:   state_nxt = S_MUL2;
      S_MUL2:     if (mul_last) state_nxt = S_TERM_END;
      S_TERM_END: begin
        if (t_r == 3'd5 && k_r == 4'd15) state_nxt = S_DET_LOAD;
        else state_nxt = S_TERM_A;
      end
      S_DET_LOAD: state_nxt = S_DET_MUL;
      S_DET_MUL:  if (mul_last) state_nxt = S_DET_END;
      S_DET_END:  state_nxt = (k_r == 4'd3) ? S_DET_FIN : S_DET_LOAD;
      S_DET_FIN:  state_nxt = (sum_r == '0) ? S_EMIT : S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_sts.done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (k_r == 4'd15) state_nxt = S_IDLE;
          else state_nxt = det_zero_r ? S_EMIT : S_DIV_GO;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    k_nxt         = k_r;
    t_nxt         = t_r;
    bit_nxt       = bit_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    det_zero_nxt  = det_zero_r;
    det_neg_nxt   = det_neg_r;
    dmag_nxt      = dmag_r;
    cof_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_sing_nxt  = out_sing_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt   = '0;
        t_nxt   = '0;
        sum_nxt = '0;
      end
      S_TERM_A: begin
        mcand_nxt = term_neg ? -PW'(rd_elem) : PW'(rd_elem);
      end
      S_TERM_B: begin
        mplier_nxt = rd_elem;
        acc_nxt    = '0;
        bit_nxt    = '0;
      end
      S_MUL1, S_MUL2, S_DET_MUL: begin
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        bit_nxt    = bit_r + BW'(1);
      end
      S_TERM_C: begin
        mplier_nxt = rd_elem;
        mcand_nxt  = acc_r;
        acc_nxt    = sum_r;
        bit_nxt    = '0;
      end
      S_TERM_END: begin
        if (t_r == 3'd5) begin
          cof_we  = 1'b1;
          sum_nxt = '0;
          t_nxt   = '0;
          k_nxt   = k_r + 4'd1;
        end else begin
          sum_nxt = acc_r;
          t_nxt   = t_r + 3'd1;
        end
      end
      S_DET_LOAD: begin
        mcand_nxt  = PW'(cof_r[k_r]);
        mplier_nxt = rd_elem;
        acc_nxt    = sum_r;
        bit_nxt    = '0;
      end
      S_DET_END: begin
        sum_nxt = acc_r;
        k_nxt   = (k_r == 4'd3) ? 4'd0 : k_r + 4'd1;
      end
      S_DET_FIN: begin
        det_zero_nxt = (sum_r == '0);
        det_neg_nxt  = sum_r[PW-1];
        dmag_nxt     = sum_r[PW-1] ? PW'(-sum_r) : PW'(sum_r);
      end
      S_DIV_GO, S_DIV_WAIT: begin
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = k_r[3:2];
          out_col_nxt   = k_r[1:0];
          out_value_nxt = det_zero_r ? 32'sd0 : 32'(div_quo);
          out_sing_nxt  = det_zero_r;
          out_sat_nxt   = !det_zero_r && div_sts.sat;
          out_last_nxt  = (k_r == 4'd15);
          k_nxt         = k_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        store_r[in_element_index] <= DATA_WIDTH'(in_element_value);
      end
    end
    if (cof_we) begin
      cof_r[k_r] <= acc_r[CW-1:0];
    end
    k_r         <= k_nxt;
    t_r         <= t_nxt;
    bit_r       <= bit_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    sum_r       <= sum_nxt;
    det_zero_r  <= det_zero_nxt;
    det_neg_r   <= det_neg_nxt;
    dmag_r      <= dmag_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_sing_r  <= out_sing_nxt;
    out_sat_r   <= out_sat_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_value       = out_value_r;
  assign out_singular    = out_sing_r;
  assign out_saturated   = out_sat_r;
  assign out_last_of_run = out_last_r;

`ifndef ASSERT_OFF
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_value == 32'sd0 && !out_saturated)
    else $error("singular result with nonzero value or saturation");
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_row == 2'd3 && out_col == 2'd3)
    else $error("last_of_run away from the last element");
  a_no_div_singular: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !det_zero_r && !div_sts.busy)
    else $error("division started on a zero determinant or while busy");
`endif

endmodule

@@ test/matrix4_inverse_adjugate_core_tb.sv @@
// testbench for the 4x4 adjugate matrix inverse core: queue-fed driver, exact predictor
module matrix4_inverse_adjugate_core_tb;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [3:0]         index;
    logic signed [31:0] value;
    logic               compute;
    logic               drain;   // hold until every expected result has come
  } load_item_t;

  typedef struct {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               singular;
    logic               saturated;
    logic               last;
  } inv_elem_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_element_index;
  logic signed [31:0] in_element_value;
  logic               in_compute_now;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [31:0] out_value;
  logic               out_singular;
  logic               out_saturated;
  logic               out_last_of_run;

  load_item_t         load_q[$];
  inv_elem_t          inverse_q[$];
  logic signed [31:0] shadow_store[16];
  int                 errors;
  int                 in_gap;
  int                 out_gap;
  int                 cycle_cnt;
  logic               long_hold;

  matrix4_inverse_adjugate_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_compute_now   (in_compute_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_singular     (out_singular),
    .out_saturated    (out_saturated),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) begin
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      return $urandom_range(20, 200);
    end
    return $urandom_range(1, 3);
  endfunction

  // element values: mostly small Q16.16 numbers, some full range, some extremes, some zero
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
    end else if (sel < 8) begin
      return $signed(32'($urandom()));
    end else if (sel == 8) begin
      return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    end
    return 32'sd0;
  endfunction

  task automatic add_load(input logic [3:0] idx, input logic signed [31:0] val,
                          input logic cn, input logic dr);
    load_item_t it;
    it.index   = idx;
    it.value   = val;
    it.compute = cn;
    it.drain   = dr;
    load_q.push_back(it);
  endtask

  // signed 3x3 minor over the cyclically shifted rows and columns
  function automatic wide_t cofactor_of(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] r1, r2, r3, c1, c2, c3;
    wide_t      e[16];
    wide_t      p, n, v;
    r1 = r + 2'd1; r2 = r + 2'd2; r3 = r + 2'd3;
    c1 = c + 2'd1; c2 = c + 2'd2; c3 = c + 2'd3;
    for (int k = 0; k < 16; k++) begin
      e[k] = shadow_store[k];
    end
    p = e[{r1, c1}] * e[{r2, c2}] * e[{r3, c3}]
      + e[{r1, c2}] * e[{r2, c3}] * e[{r3, c1}]
      + e[{r1, c3}] * e[{r2, c1}] * e[{r3, c2}];
    n = e[{r3, c1}] * e[{r2, c2}] * e[{r1, c3}]
      + e[{r3, c2}] * e[{r2, c3}] * e[{r1, c1}]
      + e[{r3, c3}] * e[{r2, c1}] * e[{r1, c2}];
    v = p - n;
    if (r[0] ^ c[0]) begin
      v = -v;
    end
    return v;
  endfunction

  // full inverse of the shadow store, sixteen results in row-major order
  task automatic predict_inverse();
    wide_t     cof[16];
    wide_t     det, dmag, num, q, lim;
    logic      neg;
    inv_elem_t r;
    lim = wide_t'(1) <<< 31;
    det = '0;
    for (int k = 0; k < 16; k++) begin
      cof[k] = cofactor_of(k[3:2], k[1:0]);
    end
    for (int k = 0; k < 4; k++) begin
      det = det + wide_t'(shadow_store[k]) * cof[k];
    end
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r.row       = k[3:2];
      r.col       = k[1:0];
      r.value     = '0;
      r.singular  = (det == 0);
      r.saturated = 1'b0;
      r.last      = (k == 15);
      if (det != 0) begin
        num = cof[{k[1:0], k[3:2]}] <<< 32;
        neg = (num < 0) != (det < 0);
        if (num < 0) begin
          num = -num;
        end
        q = num / dmag;
        if (neg && q > lim) begin
          q = lim;
          r.saturated = 1'b1;
        end else if (!neg && q >= lim) begin
          q = lim - 1;
          r.saturated = 1'b1;
        end
        if (neg) begin
          q = -q;
        end
        r.value = q[31:0];
      end
      inverse_q.push_back(r);
    end
  endtask

  // driver: present queued loads, hold them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_element_index <= '0;
      in_element_value <= '0;
      in_compute_now   <= 1'b0;
      in_gap           <= 0;
    end else if (in_valid && in_stall) begin
      // stalled transaction stays put
    end else begin
      if (in_valid) begin
        shadow_store[in_element_index] = in_element_value;
        if (in_compute_now) begin
          predict_inverse();
        end
      end
      if (in_valid && in_gap == 0) begin
        in_gap <= pick_gap();
        in_valid <= 1'b0;
      end else if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (load_q.size() > 0 && (!load_q[0].drain || inverse_q.size() == 0)) begin
        in_element_index <= load_q[0].index;
        in_element_value <= load_q[0].value;
        in_compute_now   <= load_q[0].compute;
        in_valid         <= 1'b1;
        void'(load_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off early in the run while loads keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_cnt <= 0;
      long_hold <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      long_hold <= (cycle_cnt >= 30000 && cycle_cnt < 36000);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (inverse_q.size() == 0) begin
          $error("unexpected result row %0d col %0d", out_row, out_col);
          errors++;
        end else begin
          inv_elem_t x;
          x = inverse_q.pop_front();
          if (out_row !== x.row) begin
            $error("out_row exp %0d got %0d", x.row, out_row);
            errors++;
          end
          if (out_col !== x.col) begin
            $error("out_col exp %0d got %0d", x.col, out_col);
            errors++;
          end
          if (out_value !== x.value) begin
            $error("out_value exp %h got %h", x.value, out_value);
            errors++;
          end
          if (out_singular !== x.singular) begin
            $error("out_singular exp %b got %b", x.singular, out_singular);
            errors++;
          end
          if (out_saturated !== x.saturated) begin
            $error("out_saturated exp %b got %b", x.saturated, out_saturated);
            errors++;
          end
          if (out_last_of_run !== x.last) begin
            $error("out_last_of_run exp %b got %b", x.last, out_last_of_run);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_gap   <= pick_gap();
        out_stall <= long_hold;
      end
    end
  end

  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int nseq;
    errors    = 0;
    for (int k = 0; k < 16; k++) begin
      shadow_store[k] = '0;
    end
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_element_index = '0;
    in_element_value = '0;
    in_compute_now   = 1'b0;
    out_stall        = 1'b0;

    // store after reset is all zero: singular
    add_load(4'd3, 32'sd0, 1'b1, 1'b0);
    // identity
    add_load(4'd0, 32'sh10000, 1'b0, 1'b0);
    add_load(4'd5, 32'sh10000, 1'b0, 1'b0);
    add_load(4'd10, 32'sh10000, 1'b0, 1'b0);
    add_load(4'd15, 32'sh10000, 1'b1, 1'b0);
    // tiny diagonal: inverse overflows both ways
    add_load(4'd0, 32'sd1, 1'b0, 1'b0);
    add_load(4'd5, -32'sd1, 1'b0, 1'b0);
    add_load(4'd10, 32'sd1, 1'b0, 1'b0);
    add_load(4'd15, 32'sd3, 1'b1, 1'b0);
    // extreme elements, partial reload of the store
    add_load(4'd1, 32'sh7fffffff, 1'b0, 1'b1);
    add_load(4'd4, 32'sh80000000, 1'b0, 1'b0);
    add_load(4'd0, 32'sh80000000, 1'b0, 1'b0);
    add_load(4'd15, 32'sh7fffffff, 1'b1, 1'b0);
    // loads while an inversion is queued behind the hold-off
    add_load(4'd2, 32'shffffffff, 1'b0, 1'b0);
    add_load(4'd9, 32'sh00010000, 1'b1, 1'b0);

    // random part: mostly full matrix loads ending in compute, some noise
    nseq = 0;
    while (nseq < 36) begin
      if ($urandom_range(0, 4) == 0) begin
        // partial or noisy sequence
        int len;
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          add_load(4'($urandom_range(0, 15)), pick_value(),
                   (j == len - 1) && ($urandom_range(0, 1) != 0), 1'b0);
        end
      end else begin
        for (int j = 0; j < 16; j++) begin
          add_load(4'(j), pick_value(), j == 15, (j == 0) && (nseq == 10));
        end
      end
      nseq++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (load_q.size() == 0);
    @(posedge clk);
    while (in_valid || inverse_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (inverse_q.size() != 0) begin
      $error("%0d results never came", inverse_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mi4_pkg.sv
src/mi4_div.sv
src/matrix4_inverse_adjugate_core.sv
test/matrix4_inverse_adjugate_core_tb.sv
